@@ hdl/lztbp_pkg.sv @@
`timescale 1ns / 1ps

package lztbp_pkg;

  // Operation codes of an input token
  localparam logic [1:0] OP_FIRST_LIT = 2'd0;
  localparam logic [1:0] OP_LIT       = 2'd1;
  localparam logic [1:0] OP_MATCH     = 2'd2;
  localparam logic [1:0] OP_NONE      = 2'd3;

  // Longest match length that is coded; longer ones saturate
  localparam logic [16:0] LEN_LIMIT = 17'd65536;

  // Longest token code: flag, 31-bit gamma code, 9-bit offset code
  localparam int CODE_W = 41;
  // Packing window: up to seven pending bits plus one token code
  localparam int WIN_W  = 48;
  localparam int CNT_W  = 6;

  // Offset codes
  localparam logic [7:0] OFS_ESCAPE = 8'd13;
  localparam logic [7:0] OFS_MID    = 8'd14;
  localparam logic [7:0] OFS_SHORT_BIAS = 8'd11;
  localparam logic [7:0] OFS_LONG_BIAS  = 8'd114;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  symbol;
    logic [16:0] match_len;
    logic [7:0]  match_offset;
    logic        last_token;
  } token_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } result_t;

  // Token code, MSB first and left aligned, with its bit count
  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [CNT_W-1:0]  len;
    logic              last;
  } code_t;

endpackage

@@ hdl/lztbp_front.sv @@
`timescale 1ns / 1ps

module lztbp_front (
  input  lztbp_pkg::token_t token,
  output lztbp_pkg::code_t  code
);

  logic [16:0] len_c;
  logic [16:0] len_m1;
  logic [15:0] v;
  logic [3:0]  top;
  logic [30:0] gamma;
  logic [4:0]  glen;
  logic [7:0]  o;
  logic [7:0]  o_long;
  logic [7:0]  o_short;
  logic [8:0]  ocode;
  logic [3:0]  olen;
  logic [lztbp_pkg::CODE_W-1:0] rv;
  logic [lztbp_pkg::CNT_W-1:0]  n;

  // Clamp the length and find the top set bit of length minus one
  always_comb begin
    if (token.match_len > lztbp_pkg::LEN_LIMIT) begin
      len_c = lztbp_pkg::LEN_LIMIT;
    end else if (token.match_len < 17'd2) begin
      len_c = 17'd2;
    end else begin
      len_c = token.match_len;
    end
    len_m1 = len_c - 17'd1;
    v      = len_m1[15:0];
    top    = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (v[i]) begin
        top = 4'(i);
      end
    end
  end

  // Interleave data bits under the top bit, end with a 1
  always_comb begin
    gamma    = '0;
    gamma[0] = 1'b1;
    for (int i = 0; i < 15; i++) begin
      gamma[2*i+1] = v[i] & (4'(i) < top);
    end
    glen = {top, 1'b0} + 5'd1;
  end

  // Pick the offset code
  always_comb begin
    o       = token.match_offset - 8'd1;
    o_long  = o + lztbp_pkg::OFS_LONG_BIAS;
    o_short = o + lztbp_pkg::OFS_SHORT_BIAS;
    if (o == 8'd0) begin
      ocode = 9'd0;
      olen  = 4'd2;
    end else if (o == lztbp_pkg::OFS_ESCAPE) begin
      ocode = 9'b110000000;
      olen  = 4'd9;
    end else if (o == lztbp_pkg::OFS_MID) begin
      ocode = 9'b000000010;
      olen  = 4'd3;
    end else if (o < lztbp_pkg::OFS_ESCAPE) begin
      ocode = {4'd0, o_short[4:0]};
      olen  = 4'd5;
    end else begin
      ocode = {2'b11, o_long[6:0]};
      olen  = 4'd9;
    end
  end

  // Assemble the right-aligned code, then left align it
  always_comb begin
    rv = '0;
    n  = '0;
    unique case (token.operation)
      lztbp_pkg::OP_FIRST_LIT: begin
        rv = {37'd0, token.symbol};
        n  = 6'd4;
      end
      lztbp_pkg::OP_LIT: begin
        rv = {37'd0, token.symbol};
        n  = 6'd5;
      end
      lztbp_pkg::OP_MATCH: begin
        rv = (((41'd1 << glen) | {10'd0, gamma}) << olen) | {32'd0, ocode};
        n  = 6'd1 + {1'b0, glen} + {2'b00, olen};
      end
      default: begin
        rv = '0;
        n  = '0;
      end
    endcase
    code.bits = rv << (6'(lztbp_pkg::CODE_W) - n);
    code.len  = n;
    code.last = token.last_token;
  end

endmodule

@@ hdl/lztbp_queue.sv @@
`timescale 1ns / 1ps

module lztbp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  lztbp_pkg::code_t  wr_data,
  output logic              full,
  input  logic              rd,
  output lztbp_pkg::code_t  rd_data,
  output logic              empty
);

  lztbp_pkg::code_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = slots[rd_ptr];

  // Track occupancy
  always_comb begin
    count_next = count;
    if ((wr && !full) && !(rd && !empty)) begin
      count_next = count + 2'd1;
    end else if (!(wr && !full) && (rd && !empty)) begin
      count_next = count - 2'd1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  // Hold token codes
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ hdl/lztbp_back.sv @@
`timescale 1ns / 1ps

module lztbp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  lztbp_pkg::code_t    q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output lztbp_pkg::result_t  result
);

  logic [lztbp_pkg::WIN_W-1:0] win;
  logic [lztbp_pkg::WIN_W-1:0] win_next;
  logic [lztbp_pkg::CNT_W-1:0] cnt;
  logic [lztbp_pkg::CNT_W-1:0] cnt_next;
  logic                        lst;
  logic                        lst_next;
  logic                        out_vld;
  logic                        out_vld_next;
  lztbp_pkg::result_t          out_q;
  lztbp_pkg::result_t          emit_word;
  logic                        emit;
  logic                        slot_free;
  logic                        stall;
  logic [7:0]                  base_byte;
  logic [2:0]                  base_fill;

  assign empty  = !out_vld;
  assign result = out_q;

  // Emit full bytes, flush at end of block, load the next token code
  always_comb begin
    slot_free = !out_vld || pop;
    win_next  = win;
    cnt_next  = cnt;
    lst_next  = lst;
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_word = '0;
    stall     = 1'b0;
    base_byte = win[lztbp_pkg::WIN_W-1 -: 8];
    base_fill = cnt[2:0];
    if (cnt >= 6'd8) begin
      if (slot_free) begin
        emit                = 1'b1;
        emit_word.out_byte  = win[lztbp_pkg::WIN_W-1 -: 8];
        emit_word.last_byte = lst && (cnt == 6'd8);
        win_next            = win << 8;
        cnt_next            = cnt - 6'd8;
        if (cnt == 6'd8) begin
          lst_next = 1'b0;
        end
      end
    end else begin
      stall = lst && (cnt != 6'd0) && !slot_free;
      if (lst) begin
        base_byte = 8'd0;
        base_fill = 3'd0;
      end
      if (!stall) begin
        if (lst) begin
          if (cnt != 6'd0) begin
            emit                = 1'b1;
            emit_word.out_byte  = win[lztbp_pkg::WIN_W-1 -: 8];
            emit_word.last_byte = 1'b1;
          end
          win_next = '0;
          cnt_next = '0;
          lst_next = 1'b0;
        end
        if (!q_empty) begin
          q_pop    = 1'b1;
          win_next = {base_byte, 40'd0} | ({q_data.bits, 7'd0} >> base_fill);
          cnt_next = {3'd0, base_fill} + q_data.len;
          lst_next = q_data.last;
        end
      end
    end
    out_vld_next = emit ? 1'b1 : (pop ? 1'b0 : out_vld);
  end

  // Hold packing state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      win     <= '0;
      cnt     <= '0;
      lst     <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      win     <= win_next;
      cnt     <= cnt_next;
      lst     <= lst_next;
      out_vld <= out_vld_next;
    end
  end

  // Hold the output word
  always_ff @(posedge clk) begin
    if (emit) begin
      out_q <= emit_word;
    end
  end

endmodule

@@ hdl/lz_token_bitstream_packer_core.sv @@
`timescale 1ns / 1ps

// LZ token bit packer. Tokens (first literal, literal, match) enter through a
// push/full port and are coded at once, left aligned: a match as flag,
// interleaved gamma length code and offset code, a literal as flag and symbol,
// a first literal as symbol alone. They wait in a two-entry token queue. The
// packer merges each code with the pending bits of the previous token and
// sends one byte per cycle, MSB first, while its one-word output register
// (read with empty/pop) is free or popped. It loads a token, then emits its
// completed bytes (at most six for a 41-bit match code); the flush byte of a
// block's last token goes out in the load cycle of the following token, or
// alone if the queue is empty. A block's last byte has last_byte, zero padded.
module lz_token_bitstream_packer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  lztbp_pkg::token_t   token,
  output logic                empty,
  input  logic                pop,
  output lztbp_pkg::result_t  result
);

  lztbp_pkg::code_t enc;
  lztbp_pkg::code_t q_data;
  logic             q_empty;
  logic             q_pop;

  // Code the incoming token
  lztbp_front u_front (
    .token (token),
    .code  (enc)
  );

  // Buffer coded tokens
  lztbp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (enc),
    .full    (full),
    .rd      (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // Pack codes into bytes
  lztbp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

`ifndef SYNTHESIS
  // The packer only takes a code that is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("packer popped an empty token queue");

  // A queued code never exceeds the longest token
  a_code_len: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> (q_data.len <= 6'(lztbp_pkg::CODE_W)))
    else $error("token code longer than the packing window allows");

  // A literal pushed into an empty queue is coded as a short code
  a_lit_len: assert property (@(posedge clk) disable iff (rst)
    (push && !full && token.operation == lztbp_pkg::OP_LIT && q_empty && !q_pop)
      |=> (q_data.len == 6'd5))
    else $error("literal token lost its flag or symbol bits");
`endif

endmodule
